FILE: rtl/core/pslc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pslc_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN     = 3'd1,
    PH_CONTENT = 3'd2,
    PH_TRAIL   = 3'd3,
    PH_IGNORE  = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_CHAR     = 3'd0,
    K_SPACES   = 3'd1,
    K_NEWLINE  = 3'd2,
    K_REVISION = 3'd3,
    K_BADFMT   = 3'd4,
    K_FINISHED = 3'd5
  } kind_t;

  localparam logic [2:0] HDR_LANG_IDX = 3'd4;
  localparam logic [2:0] HDR_REV_IDX  = 3'd5;
  localparam logic [2:0] HDR_LAST_IDX = 3'd7;
  localparam logic [7:0] LANG_OK      = 8'd1;
  localparam logic [7:0] CHAR_MASK    = 8'h7f;
  localparam logic [7:0] SHORT_LEN    = 8'd2;

  // one decoded request; a leading newline is emitted first when has_nl is set
  typedef struct packed {
    logic       has_nl;
    kind_t      kind;
    logic [7:0] value;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/pslc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pslc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_end_of_input,
  input  wire logic            q_full,
  output logic                 in_stall,
  output logic                 push_valid,
  output pslc_pkg::entry_t     push_entry
);
  import pslc_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [2:0] hdr_idx_r, hdr_idx_nxt;
  logic       lang_ok_r, lang_ok_nxt;
  logic [7:0] left_r, left_nxt;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    lang_ok_nxt = lang_ok_r;
    left_nxt    = left_r;
    push_valid  = 1'b0;
    push_entry  = '{has_nl: 1'b0, kind: K_FINISHED, value: 8'd0};
    if (accept) begin
      if (in_end_of_input) begin
        push_valid        = 1'b1;
        push_entry.has_nl = (phase_r == PH_CONTENT) || (phase_r == PH_TRAIL);
        phase_nxt         = PH_HEADER;
        hdr_idx_nxt       = 3'd0;
        lang_ok_nxt       = 1'b0;
        left_nxt          = 8'd0;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (hdr_idx_r == HDR_LANG_IDX) begin
              lang_ok_nxt = (in_data_byte == LANG_OK);
            end
            if (hdr_idx_r == HDR_REV_IDX && !lang_ok_r) begin
              push_valid      = 1'b1;
              push_entry.kind = K_BADFMT;
              phase_nxt       = PH_IGNORE;
            end else begin
              if (hdr_idx_r == HDR_REV_IDX) begin
                push_valid       = 1'b1;
                push_entry.kind  = K_REVISION;
                push_entry.value = in_data_byte;
              end
              if (hdr_idx_r == HDR_LAST_IDX) begin
                phase_nxt   = PH_LEN;
                hdr_idx_nxt = 3'd0;
              end else begin
                hdr_idx_nxt = hdr_idx_r + 3'd1;
              end
            end
          end
          PH_LEN: begin
            if (in_data_byte == 8'd0) begin
              phase_nxt = PH_IGNORE;
            end else if (in_data_byte <= SHORT_LEN) begin
              left_nxt  = 8'd0;
              phase_nxt = PH_TRAIL;
            end else begin
              left_nxt  = in_data_byte - SHORT_LEN;
              phase_nxt = PH_CONTENT;
            end
          end
          PH_CONTENT: begin
            if (in_data_byte[7]) begin
              push_valid       = 1'b1;
              push_entry.kind  = K_CHAR;
              push_entry.value = in_data_byte & CHAR_MASK;
            end else if (in_data_byte != 8'd0) begin
              push_valid       = 1'b1;
              push_entry.kind  = K_SPACES;
              push_entry.value = in_data_byte;
            end
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            push_valid      = 1'b1;
            push_entry.kind = K_NEWLINE;
            phase_nxt       = PH_LEN;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= 3'd0;
      lang_ok_r <= 1'b0;
      left_r    <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      lang_ok_r <= lang_ok_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pslc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module pslc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire pslc_pkg::entry_t push_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output pslc_pkg::entry_t      head_entry
);
  import pslc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pslc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pslc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  wire pslc_pkg::entry_t head_entry,
  output logic                  pop,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output logic [2:0]            out_kind,
  output logic [7:0]            out_value,
  output logic                  out_last
);
  import pslc_pkg::*;

  logic       valid_r, valid_nxt;
  logic       half_r, half_nxt;
  kind_t      kind_r, kind_nxt;
  logic [7:0] value_r, value_nxt;
  logic       last_r, last_nxt;
  logic       take, load;

  assign take = !valid_r || !out_stall;

  always_comb begin
    pop       = 1'b0;
    load      = 1'b0;
    half_nxt  = half_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    last_nxt  = last_r;
    if (take && head_valid) begin
      load = 1'b1;
      if (head_entry.has_nl && !half_r) begin
        kind_nxt  = K_NEWLINE;
        value_nxt = 8'd0;
        last_nxt  = 1'b0;
        half_nxt  = 1'b1;
      end else begin
        kind_nxt  = head_entry.kind;
        value_nxt = head_entry.value;
        last_nxt  = 1'b1;
        half_nxt  = 1'b0;
        pop       = 1'b1;
      end
    end
    valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

FILE: rtl/core/packed_source_line_decoder.sv
// packed source line decoder
// input channel: in_valid / in_stall carry one file byte (in_data_byte) or an
// end-of-file mark (in_end_of_input) per request; one request is taken per cycle
// while the internal queue has room.
// output channel: out_valid / out_stall carry results (out_kind, out_value,
// out_last); out_last marks the final result caused by an input request.
// a request yields zero, one or two results; each is registered in the queue
// and then in the output register before it appears on the output.
// throughput: one request per cycle while the queue has room; an end of file
// inside a record gives a newline and then a finished result from the back end.
// the front end decodes into a queue of QUEUE_DEPTH entries; when the receiver
// stalls, results hold steady and the queue fills, after which in_stall rises.
// reset (rst_n low, synchronous) empties the queue and output register and
// returns the decoder to the start of a file header; every end-of-file request
// does the same for the decoder state.
`timescale 1ns / 1ps
`default_nettype none

module packed_source_line_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_input,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_value,
  output logic            out_last
);
  import pslc_pkg::*;

  logic   q_full;
  logic   push_valid;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head_entry;

  pslc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .in_stall        (in_stall),
    .push_valid      (push_valid),
    .push_entry      (push_entry)
  );

  pslc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  pslc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_kind   (out_kind),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire
